>>> rtl/core/cba_pkg.sv
package cba_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 32;
    localparam int CFG_CNT_W  = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Block geometry. The block size is fixed, so address-to-block math is a shift.
    localparam int NUM_BLOCKS_DEF = 1024;
    localparam int BLOCK_BYTES    = 4096;
    localparam int BLK_SHIFT      = $clog2(BLOCK_BYTES);
    localparam int BLK_W          = ADDR_W - BLK_SHIFT;
    localparam int NEED_W         = BLK_W + 1;

    // Reset value of the covered block count.
    localparam logic [CFG_CNT_W-1:0] BLOCKS_RESET = CFG_CNT_W'(1024);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    // One table entry per block.
    typedef struct packed {
        logic has_next;
        logic first;
        logic taken;
    } entry_t;

    // Request fields.
    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] size_bytes;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    // Result fields.
    typedef struct packed {
        logic [ADDR_W-1:0] alloc_address;
        logic              status;
    } result_t;

endpackage

>>> rtl/core/cba_table.sv
module cba_table
    import cba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(NUM_BLOCKS)-1:0] waddr,
    input  entry_t                        wdata,
    input  logic [$clog2(NUM_BLOCKS)-1:0] raddr,
    output entry_t                        rdata
);

    entry_t mem [NUM_BLOCKS];
    entry_t rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/cba_seq.sv
module cba_seq
    import cba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  req_t                          req,
    input  logic [BLK_W-1:0]              base_hi,
    input  logic [((($clog2(NUM_BLOCKS+1)) > CFG_CNT_W) ?
                   $clog2(NUM_BLOCKS+1) : CFG_CNT_W)-1:0] covered,
    output logic                          tbl_we,
    output logic [$clog2(NUM_BLOCKS)-1:0] tbl_waddr,
    output entry_t                        tbl_wdata,
    output logic [$clog2(NUM_BLOCKS)-1:0] tbl_raddr,
    input  entry_t                        tbl_rdata,
    output logic                          done,
    output result_t                       result
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CW    = ($clog2(NUM_BLOCKS+1) > CFG_CNT_W) ?
                           $clog2(NUM_BLOCKS+1) : CFG_CNT_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHECK = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MARK  = 6'b010000,
        S_WALK  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [CW-1:0]      run_reg, run_next;
    logic [CW-1:0]      need_reg, need_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               first_reg, first_next;
    req_t               req_reg, req_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;

    logic [ADDR_W:0]    size_sum;
    logic [NEED_W-1:0]  need_full;
    logic [IDX_W-1:0]   ptr_inc;
    logic [CW-1:0]      run_inc;
    logic               at_last;
    logic [BLK_W-1:0]   free_hi;
    logic [BLK_W-1:0]   blk;
    logic [BLK_W-1:0]   alloc_hi;

    // Shared step unit: pointer increment, run count and end-of-heap compare.
    assign ptr_inc   = ptr_reg + IDX_W'(1);
    assign run_inc   = run_reg + CW'(1);
    assign at_last   = ((CW'(ptr_reg) + CW'(1)) == covered);

    // Size rounded up to whole blocks.
    assign size_sum  = {1'b0, req_reg.size_bytes} + (ADDR_W+1)'(BLOCK_BYTES - 1);
    assign need_full = size_sum[ADDR_W:BLK_SHIFT];

    // Block index of a free address relative to the aligned base.
    assign free_hi   = req_reg.free_address[ADDR_W-1:BLK_SHIFT];
    assign blk       = free_hi - base_hi;

    // Address of the allocated run.
    assign alloc_hi  = base_hi + BLK_W'(start_reg);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        start_next  = start_reg;
        run_next    = run_reg;
        need_next   = need_reg;
        rem_next    = rem_reg;
        first_next  = first_reg;
        req_next    = req_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        tbl_we      = 1'b0;
        tbl_wdata   = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the table to free after reset.
                tbl_we = 1'b1;
                if (ptr_reg == IDX_W'(NUM_BLOCKS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (req_reg.cmd == CMD_ALLOC)
                begin
                    if ((req_reg.size_bytes == '0) || (need_full > NEED_W'(covered)))
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        result_next = '{alloc_address: '0, status: ST_FAIL};
                    end
                    else
                    begin
                        need_next  = CW'(need_full);
                        run_next   = '0;
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if ((free_hi < base_hi) || (blk >= BLK_W'(covered)))
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        result_next = '{alloc_address: '0, status: ST_OK};
                    end
                    else
                    begin
                        ptr_next   = IDX_W'(blk);
                        state_next = S_WALK;
                    end
                end
            end
            S_SCAN:
            begin
                // First-fit search, one entry per cycle.
                if (tbl_rdata.taken)
                begin
                    run_next = '0;
                end
                else
                begin
                    run_next = run_inc;
                    if (run_reg == '0)
                    begin
                        start_next = ptr_reg;
                    end
                end

                if (!tbl_rdata.taken && (run_inc == need_reg))
                begin
                    ptr_next   = (run_reg == '0) ? ptr_reg : start_reg;
                    rem_next   = need_reg;
                    first_next = 1'b1;
                    state_next = S_MARK;
                end
                else if (at_last)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{alloc_address: '0, status: ST_FAIL};
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_MARK:
            begin
                // Write the chain, one entry per cycle.
                tbl_we     = 1'b1;
                tbl_wdata  = '{has_next: (rem_reg != CW'(1)), first: first_reg, taken: 1'b1};
                first_next = 1'b0;
                if (rem_reg == CW'(1))
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{alloc_address: {alloc_hi, BLK_SHIFT'(0)}, status: ST_OK};
                end
                else
                begin
                    rem_next = rem_reg - CW'(1);
                    ptr_next = ptr_inc;
                end
            end
            S_WALK:
            begin
                // Clear along the chain while the next entry is already being read.
                tbl_we = 1'b1;
                if (tbl_rdata.has_next && !at_last)
                begin
                    ptr_next = ptr_inc;
                end
                else
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{alloc_address: '0, status: ST_OK};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Table port addresses follow the pointer.
    assign tbl_waddr = ptr_reg;
    assign tbl_raddr = ptr_next;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        run_reg    <= run_next;
        need_reg   <= need_next;
        rem_reg    <= rem_next;
        first_reg  <= first_next;
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/contiguous_block_allocator.sv
// First-fit block allocator over a heap of fixed 4096-byte blocks. A request is taken
// when start is high and busy is low; its result appears on result for exactly one
// cycle with done high and must be captured then, since the block cannot be stalled.
// The block table has one write port and one registered read port and is visited one
// entry per cycle: an allocation scans entries until the first long-enough free run
// ends, then marks the run; it fails at once when the size is zero or exceeds the
// heap, and fails when the scan reaches the last covered entry. A free clears the
// chain from its first entry, and ends at once when the address lies outside the heap.
// After reset the table is cleared with busy high; configuration writes are taken at
// any time but should only be made while no request is in progress.
module contiguous_block_allocator
    import cba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  req,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CW    = ($clog2(NUM_BLOCKS+1) > CFG_CNT_W) ?
                           $clog2(NUM_BLOCKS+1) : CFG_CNT_W;

    logic [ADDR_W-1:0]    base_address_reg;
    logic [CFG_CNT_W-1:0] blocks_in_use_reg;
    logic [CW-1:0]        covered;

    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    entry_t               tbl_wdata;
    logic [IDX_W-1:0]     tbl_raddr;
    entry_t               tbl_rdata;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg  <= '0;
            blocks_in_use_reg <= BLOCKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_ADDRESS:  base_address_reg  <= cfg_data;
                CFG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_data[CFG_CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Entries the heap covers, limited to the table size.
    always_comb
    begin
        if (CW'(blocks_in_use_reg) > CW'(NUM_BLOCKS))
        begin
            covered = CW'(NUM_BLOCKS);
        end
        else
        begin
            covered = CW'(blocks_in_use_reg);
        end
    end

    cba_seq #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .base_hi   (base_address_reg[ADDR_W-1:BLK_SHIFT]),
        .covered   (covered),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .done      (done),
        .result    (result)
    );

    cba_table #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

endmodule

>>> rtl/core/cba_checker.sv
module cba_checker
    import cba_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // An accepted request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a request");

    // No result can appear in the cycle right after a request is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early after accept");

    // The block is idle again whenever a result is shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // A failed request reports address zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_FAIL)) |-> (result.alloc_address == '0))
        else $error("failed request with nonzero address");

endmodule

bind contiguous_block_allocator cba_checker u_cba_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
